// ===== design/fuzzy_art_rectangle_map_defines.svh =====
// Assertion macros for the fuzzy ART rectangle map.
`ifndef FUZZY_ART_RECTANGLE_MAP_DEFINES_SVH
`define FUZZY_ART_RECTANGLE_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define FARM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FARM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define FARM_ASSERT(lbl, prop, msg)
`define FARM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== design/farm_pkg.sv =====
// Shared types and constants of the fuzzy ART rectangle map.
package farm_pkg;
  localparam int NODE_MAX = 64;
  localparam int IDX_W = $clog2(NODE_MAX);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RATE   = 2'd2;
  localparam logic [1:0] CFG_VIG    = 2'd3;
  localparam logic MODE_ADD = 1'b0;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_DIV  = 12'h002,
    S_ARD  = 12'h004,
    S_ASUM = 12'h008,
    S_AMA  = 12'h010,
    S_AMB  = 12'h020,
    S_URD  = 12'h040,
    S_UPD  = 12'h080,
    S_WR   = 12'h100,
    S_CRD  = 12'h200,
    S_CTST = 12'h400,
    S_CMV  = 12'h800
  } state_e;
endpackage

// ===== design/fuzzy_art_rectangle_map.sv =====
// Top level of the fuzzy ART rectangle map: sequencer, node memory and result port.
// An item is taken when start is high and busy is low; its single result appears
// with done_o for one cycle and must be taken then, since the receiver cannot stall.
// An add item runs two serial normalizations and a choice scan over the stored nodes
// (one memory read per node, and two cross multiplies once a passing node is held),
// closes the scan and updates the chosen node; with no passing node, a new node is
// written in the closing step unless the table is full. A clean item runs four
// normalizations, tests each kept node and moves the last node into the place of each
// removed one, paced by the single read port of the node memory, and closes. The result
// beat is registered from the close. The node memory needs no clearing pass after reset.
`include "fuzzy_art_rectangle_map_defines.svh"
module fuzzy_art_rectangle_map import farm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             start,
  output logic             busy,
  input  logic             mode_i,
  input  logic [15:0]      point_x_i,
  input  logic [15:0]      point_y_i,
  input  logic [15:0]      radius_i,
  output logic             done_o,
  output logic [5:0]       node_index_o,
  output logic             created_new_o,
  output logic             table_full_o,
  output logic [6:0]       removed_count_o,
  output logic [6:0]       active_count_o
);
  logic [15:0] width_q, height_q, rate_q, vig_q;
  logic        mode_q;
  logic [15:0] px_q, py_q, rad_q;

  state_e      state_q, state_d;
  logic [1:0]  dsel_q, dsel_d;
  logic        dgo_q, dgo_d;
  logic [15:0] n_q [4];
  logic [15:0] n_d [4];
  logic [CNT_W-1:0] j_q, j_d, count_q, count_d, removed_q, removed_d;
  logic [IDX_W-1:0] best_q, best_d;
  logic        found_q, found_d, pass_q, pass_d;
  logic [17:0] s_q, s_d, w_q, w_d, bs_q, bs_d, bw_q, bw_d;
  logic [36:0] pa_q, pa_d, pb;
  logic [1:0]  k_q, k_d;
  logic [15:0] upd_q [4];
  logic [15:0] upd_d [4];

  logic        done_d, created_d, full_d;
  logic [IDX_W-1:0] oidx_d;
  logic [CNT_W-1:0] orem_d;

  logic [63:0] mem [NODE_MAX];
  logic [63:0] rdata_q, wr_data;
  logic        rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0] in_v [4];
  logic [15:0] m_v [4];
  logic [17:0] s_sum, w_sum;
  logic [15:0] ek, mk, dk;
  logic [31:0] prod, acc;
  logic [15:0] sx, sy;
  logic signed [17:0] up1, up2, vp1, vp2, uj1, uj2, vj1, vj2;
  logic        in_u, in_vv, in_c, accept;

  farm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);

  assign div_req.start = dgo_q;
  assign div_req.num = dsel_q[1] ? rad_q : (dsel_q[0] ? py_q : px_q);
  assign div_req.den = dsel_q[0] ? height_q : width_q;

  assign in_v[0] = n_q[0];
  assign in_v[1] = n_q[1];
  assign in_v[2] = ONE_Q15 - n_q[0];
  assign in_v[3] = ONE_Q15 - n_q[1];

  always_comb begin
    s_sum = '0;
    w_sum = '0;
    for (int i = 0; i < 4; i++) begin
      m_v[i] = (in_v[i] < rdata_q[16*i +: 16]) ? in_v[i] : rdata_q[16*i +: 16];
      s_sum = s_sum + 18'(m_v[i]);
      w_sum = w_sum + 18'(rdata_q[16*i +: 16]);
    end
  end

  assign ek = rdata_q[16*k_q +: 16];
  assign mk = m_v[k_q];
  assign dk = ek - mk;
  assign prod = rate_q * dk;
  assign acc = {ek, 16'd0} - prod + 32'd32768;
  assign pb = bs_q * ({1'b0, w_q} + 19'd1);

  assign sx = (ONE_Q15 - n_q[0] > n_q[2]) ? (ONE_Q15 - n_q[0] - n_q[2]) : 16'd0;
  assign sy = (ONE_Q15 - n_q[1] > n_q[3]) ? (ONE_Q15 - n_q[1] - n_q[3]) : 16'd0;
  assign up1 = (n_q[0] > n_q[2]) ? 18'(n_q[0] - n_q[2]) : 18'sd0;
  assign up2 = (n_q[1] > n_q[3]) ? 18'(n_q[1] - n_q[3]) : 18'sd0;
  assign vp1 = 18'(ONE_Q15) - 18'(sx);
  assign vp2 = 18'(ONE_Q15) - 18'(sy);
  assign uj1 = 18'(rdata_q[15:0]);
  assign uj2 = 18'(rdata_q[31:16]);
  assign vj1 = 18'(ONE_Q15) - 18'(rdata_q[47:32]);
  assign vj2 = 18'(ONE_Q15) - 18'(rdata_q[63:48]);
  assign in_u = uj1 < vp1 && uj1 > up1 && uj2 < vp2 && uj2 > up2;
  assign in_vv = vj1 > up1 && vj1 < vp1 && vj2 > up2 && vj2 < vp2;
  assign in_c = (vj2 > up2 && uj1 < vp1 && vj1 > vp1 && uj2 < up2)
             || (vj1 > up1 && uj2 < vp2 && vj2 > vp2 && uj1 < up1);

  always_comb begin
    state_d = state_q;
    dsel_d = dsel_q;
    dgo_d = 1'b0;
    n_d = n_q;
    j_d = j_q;
    count_d = count_q;
    removed_d = removed_q;
    best_d = best_q;
    found_d = found_q;
    pass_d = pass_q;
    s_d = s_q;
    w_d = w_q;
    bs_d = bs_q;
    bw_d = bw_q;
    pa_d = pa_q;
    k_d = k_q;
    upd_d = upd_q;
    done_d = 1'b0;
    created_d = 1'b0;
    full_d = 1'b0;
    oidx_d = '0;
    orem_d = '0;
    rd_en = 1'b0;
    rd_addr = j_q[IDX_W-1:0];
    wr_en = 1'b0;
    wr_addr = j_q[IDX_W-1:0];
    wr_data = rdata_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIV;
          dsel_d = 2'd0;
          dgo_d = 1'b1;
          j_d = '0;
          found_d = 1'b0;
          removed_d = '0;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          n_d[dsel_q] = div_rsp.quo;
          if (mode_q == MODE_ADD && dsel_q == 2'd1) begin
            state_d = S_ARD;
          end else if (dsel_q == 2'd3) begin
            state_d = S_CRD;
          end else begin
            dsel_d = dsel_q + 2'd1;
            dgo_d = 1'b1;
          end
        end
      end
      S_ARD: begin
        if (j_q < count_q) begin
          rd_en = 1'b1;
          state_d = S_ASUM;
        end else if (found_q) begin
          rd_en = 1'b1;
          rd_addr = best_q;
          k_d = 2'd0;
          state_d = S_URD;
        end else begin
          state_d = S_IDLE;
          done_d = 1'b1;
          if (count_q < CNT_W'(NODE_MAX)) begin
            wr_en = 1'b1;
            wr_addr = count_q[IDX_W-1:0];
            wr_data = {in_v[3], in_v[2], in_v[1], in_v[0]};
            oidx_d = count_q[IDX_W-1:0];
            created_d = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            full_d = 1'b1;
          end
        end
      end
      S_ASUM: begin
        s_d = s_sum;
        w_d = w_sum;
        pass_d = s_sum >= 18'(vig_q);
        state_d = S_AMA;
      end
      S_AMA: begin
        if (!pass_q) begin
          j_d = j_q + 1'b1;
          state_d = S_ARD;
        end else if (!found_q) begin
          found_d = 1'b1;
          best_d = j_q[IDX_W-1:0];
          bs_d = s_q;
          bw_d = w_q;
          j_d = j_q + 1'b1;
          state_d = S_ARD;
        end else begin
          pa_d = s_q * ({1'b0, bw_q} + 19'd1);
          state_d = S_AMB;
        end
      end
      S_AMB: begin
        if (pa_q > pb) begin
          best_d = j_q[IDX_W-1:0];
          bs_d = s_q;
          bw_d = w_q;
        end
        j_d = j_q + 1'b1;
        state_d = S_ARD;
      end
      S_URD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        upd_d[k_q] = acc[31:16];
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        wr_en = 1'b1;
        wr_addr = best_q;
        wr_data = {upd_q[3], upd_q[2], upd_q[1], upd_q[0]};
        oidx_d = best_q;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      S_CRD: begin
        if (j_q < count_q) begin
          rd_en = 1'b1;
          state_d = S_CTST;
        end else begin
          orem_d = removed_q;
          done_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CTST: begin
        if (in_u || in_vv || in_c) begin
          j_d = j_q + 1'b1;
          state_d = S_CRD;
        end else begin
          count_d = count_q - 1'b1;
          removed_d = removed_q + 1'b1;
          rd_en = 1'b1;
          rd_addr = count_d[IDX_W-1:0];
          state_d = S_CMV;
        end
      end
      S_CMV: begin
        wr_en = 1'b1;
        state_d = S_CRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      px_q <= point_x_i;
      py_q <= point_y_i;
      rad_q <= radius_i;
    end
    n_q <= n_d;
    s_q <= s_d;
    w_q <= w_d;
    bs_q <= bs_d;
    bw_q <= bw_d;
    pa_q <= pa_d;
    upd_q <= upd_d;
    pass_q <= pass_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 16'd5000;
      height_q <= 16'd4000;
      rate_q <= 16'd65535;
      vig_q <= 16'd49152;
      state_q <= S_IDLE;
      dsel_q <= '0;
      dgo_q <= 1'b0;
      j_q <= '0;
      count_q <= '0;
      removed_q <= '0;
      best_q <= '0;
      found_q <= 1'b0;
      k_q <= '0;
      done_o <= 1'b0;
      node_index_o <= '0;
      created_new_o <= 1'b0;
      table_full_o <= 1'b0;
      removed_count_o <= '0;
      active_count_o <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_RATE:   rate_q <= cfg_data_i;
          CFG_VIG:    vig_q <= cfg_data_i;
          default:    width_q <= width_q;
        endcase
      end
      state_q <= state_d;
      dsel_q <= dsel_d;
      dgo_q <= dgo_d;
      j_q <= j_d;
      count_q <= count_d;
      removed_q <= removed_d;
      best_q <= best_d;
      found_q <= found_d;
      k_q <= k_d;
      done_o <= done_d;
      if (done_d) begin
        node_index_o <= 6'(oidx_d);
        created_new_o <= created_d;
        table_full_o <= full_d;
        removed_count_o <= 7'(orem_d);
        active_count_o <= 7'(count_d);
      end
    end
  end

  `FARM_ASSERT(a_done_idle, !done_o || !busy, "result beat while busy")
  `FARM_ASSERT(a_count_max, count_q <= CNT_W'(NODE_MAX), "node count over table size")
  `FARM_ASSERT(a_new_not_full, !(done_o && created_new_o && table_full_o), "created and full")
  `FARM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
endmodule

// ===== design/farm_div.sv =====
// Bit-serial normalizer: min(32768, floor(num * 32768 / den)), den of 0 taken as 1.
module farm_div import farm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [15:0] rem_q, den_q;
  logic [30:0] quo_q, num_q;
  logic [16:0] part;
  logic        ge;

  assign part = {rem_q, num_q[30]};
  assign ge = part >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      num_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q <= {req_i.num, 15'd0};
        den_q <= (req_i.den == 16'd0) ? 16'd1 : req_i.den;
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 5'd31;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= ge ? 16'(part - {1'b0, den_q}) : part[15:0];
        quo_q <= {quo_q[29:0], ge};
        num_q <= {num_q[29:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo = (quo_q > 31'(ONE_Q15)) ? ONE_Q15 : quo_q[15:0];
endmodule
